[rtl/ips_patch_stream_applier_core_defines.svh]
// Assertion macros for the IPS patch applier.
// Used by the top level; no other dependencies.
`ifndef IPS_PATCH_STREAM_APPLIER_CORE_DEFINES_SVH
`define IPS_PATCH_STREAM_APPLIER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define IPSA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define IPSA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IPSA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define IPSA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/ipsa_pkg.sv]
// Shared types and constants of the IPS patch applier.
// No dependencies.
package ipsa_pkg;

  localparam int ADDR_W = 25;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_FILL   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_BOUNDS    = 2'd2;
  localparam logic [1:0] ST_BAD_HDR   = 2'd3;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_ADDR   = 3'd1;
  localparam logic [2:0] PH_LEN    = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_RLEN   = 3'd4;
  localparam logic [2:0] PH_FILL   = 3'd5;

  localparam logic [23:0] EOF_MARK   = 24'h454F46;
  localparam logic [3:0]  MIN_STREAM = 4'd8;
  localparam logic [2:0]  HDR_LEN    = 3'd5;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] target_address;
    logic [15:0]       run_length;
    logic [7:0]        byte_value;
    logic [1:0]        status;
    logic [ADDR_W-1:0] needed_size;
    logic              end_of_run;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h50;
      3'd1:    b = 8'h41;
      3'd2:    b = 8'h54;
      3'd3:    b = 8'h43;
      3'd4:    b = 8'h48;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[rtl/ipsa_parser.sv]
// Record parser of the IPS patch applier: one byte per request, up to two results.
// Depends on ipsa_pkg.
module ipsa_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [7:0]                    patch_byte,
  input  logic                          final_byte,
  input  logic                          measure_mode,
  input  logic [ipsa_pkg::ADDR_W-1:0]   target_size,
  output ipsa_pkg::result_t [1:0]       res,
  output logic [1:0]                    res_cnt
);
  import ipsa_pkg::*;

  logic [2:0]        phase, phase_next;
  logic [2:0]        idx, idx_next;
  logic [3:0]        seen, seen_next;
  logic [23:0]       addr, addr_next;
  logic [15:0]       len, len_next;
  logic [15:0]       rem, rem_next;
  logic [ADDR_W-1:0] ext, ext_next;
  logic [1:0]        err, err_next;

  logic [2:0]        idx_inc;
  logic [23:0]       addr_shift;
  logic [15:0]       len_shift;
  logic [15:0]       rem_dec;
  logic [15:0]       wr_off;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rec_end;
  logic              eof_ok;
  logic              body_valid;
  result_t           body;
  result_t           fin_res;

  assign idx_inc    = idx + 3'd1;
  assign addr_shift = {addr[15:0], patch_byte};
  assign len_shift  = {len[7:0], patch_byte};
  assign rem_dec    = rem - 16'd1;
  assign wr_off     = len - rem;
  assign wr_addr    = {1'b0, addr} + {{(ADDR_W-16){1'b0}}, wr_off};

  always_comb begin
    phase_next = phase;
    idx_next   = idx;
    seen_next  = (seen < MIN_STREAM) ? seen + 4'd1 : seen;
    addr_next  = addr;
    len_next   = len;
    rem_next   = rem;
    ext_next   = ext;
    err_next   = err;
    eof_ok     = 1'b0;
    rec_end    = '0;
    body_valid = 1'b0;
    body       = '0;
    fin_res    = '0;
    res        = '0;
    res_cnt    = 2'd0;

    if (err == ST_OK) begin
      case (phase)
        PH_HEADER: begin
          if (idx >= HDR_LEN || patch_byte != magic_byte(idx)) begin
            err_next = ST_BAD_HDR;
          end
          idx_next = idx_inc;
          if (idx_inc >= HDR_LEN) begin
            idx_next   = 3'd0;
            phase_next = PH_ADDR;
          end
        end
        PH_ADDR: begin
          addr_next = addr_shift;
          idx_next  = idx_inc;
          if (idx_inc >= 3'd3) begin
            idx_next   = 3'd0;
            eof_ok     = (addr_shift == EOF_MARK) && final_byte;
            len_next   = 16'd0;
            phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          len_next = len_shift;
          idx_next = idx_inc;
          rec_end  = {1'b0, addr} + {{(ADDR_W-16){1'b0}}, len_shift};
          if (idx_inc >= 3'd2) begin
            idx_next = 3'd0;
            if (len_shift == 16'd0) begin
              phase_next = PH_RLEN;
            end else begin
              rem_next   = len_shift;
              phase_next = PH_DATA;
              if (measure_mode) begin
                if (rec_end > ext) ext_next = rec_end;
              end else if (!final_byte && rec_end > target_size) begin
                err_next = ST_BOUNDS;
              end
            end
          end
        end
        PH_DATA: begin
          if (!measure_mode) begin
            body_valid          = 1'b1;
            body.kind           = KIND_WRITE;
            body.target_address = wr_addr;
            body.byte_value     = patch_byte;
          end
          rem_next = rem_dec;
          if (rem_dec == 16'd0) phase_next = PH_ADDR;
        end
        PH_RLEN: begin
          len_next = len_shift;
          idx_next = idx_inc;
          if (idx_inc >= 3'd2) begin
            idx_next   = 3'd0;
            phase_next = PH_FILL;
          end
        end
        PH_FILL: begin
          rec_end = {1'b0, addr} + {{(ADDR_W-16){1'b0}}, len};
          if (measure_mode) begin
            if (rec_end > ext) ext_next = rec_end;
          end else if (rec_end > target_size) begin
            err_next = ST_BOUNDS;
          end else begin
            body_valid          = 1'b1;
            body.kind           = KIND_FILL;
            body.target_address = {1'b0, addr};
            body.run_length     = len;
            body.byte_value     = patch_byte;
          end
          phase_next = PH_ADDR;
        end
        default: begin
          phase_next = PH_HEADER;
          idx_next   = 3'd0;
        end
      endcase
    end

    fin_res.kind        = KIND_FINISH;
    fin_res.needed_size = ext_next;
    fin_res.end_of_run  = 1'b1;
    if (seen_next < MIN_STREAM) begin
      fin_res.status = ST_BAD_HDR;
    end else if (err_next != ST_OK) begin
      fin_res.status = err_next;
    end else begin
      fin_res.status = eof_ok ? ST_OK : ST_TRUNCATED;
    end

    if (final_byte) begin
      if (body_valid) begin
        res[0]  = body;
        res[1]  = fin_res;
        res_cnt = 2'd2;
      end else begin
        res[0]  = fin_res;
        res_cnt = 2'd1;
      end
      phase_next = PH_HEADER;
      idx_next   = 3'd0;
      seen_next  = 4'd0;
      addr_next  = 24'd0;
      len_next   = 16'd0;
      rem_next   = 16'd0;
      ext_next   = '0;
      err_next   = ST_OK;
    end else if (body_valid) begin
      res[0]            = body;
      res[0].end_of_run = 1'b1;
      res_cnt           = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      idx   <= 3'd0;
      seen  <= 4'd0;
      addr  <= 24'd0;
      len   <= 16'd0;
      rem   <= 16'd0;
      ext   <= '0;
      err   <= ST_OK;
    end else if (step) begin
      phase <= phase_next;
      idx   <= idx_next;
      seen  <= seen_next;
      addr  <= addr_next;
      len   <= len_next;
      rem   <= rem_next;
      ext   <= ext_next;
      err   <= err_next;
    end
  end

endmodule

[rtl/ipsa_out_fifo.sv]
// Result queue of the IPS patch applier: takes up to two results a cycle, gives one.
// Depends on ipsa_pkg.
module ipsa_out_fifo (
  input  logic                    clk,
  input  logic                    rst,
  input  ipsa_pkg::result_t [1:0] push_data,
  input  logic [1:0]              push_cnt,
  output logic                    room,
  output logic                    out_valid,
  input  logic                    out_ready,
  output ipsa_pkg::result_t       out_data
);
  import ipsa_pkg::*;

  result_t             mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr;
  logic [OQ_PTR_W-1:0] rd_ptr;
  logic [OQ_CNT_W-1:0] count;
  logic [OQ_PTR_W-1:0] wr_ptr_b;
  logic                pop;

  assign room      = count <= OQ_CNT_W'(OQ_DEPTH - 2);
  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_b  = wr_ptr + OQ_PTR_W'(1);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem[wr_ptr] <= push_data[0];
    if (push_cnt == 2'd2) mem[wr_ptr_b] <= push_data[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_PTR_W'(push_cnt);
      rd_ptr <= rd_ptr + OQ_PTR_W'(pop);
      count  <= count + OQ_CNT_W'(push_cnt) - OQ_CNT_W'(pop);
    end
  end

endmodule

[rtl/ips_patch_stream_applier_core.sv]
// IPS patch applier top level: configuration registers, parser and result queue.
// Depends on ipsa_pkg, ipsa_parser, ipsa_out_fifo and the assertion macro header.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one patch byte per request;
//    final_byte marks the last byte of a patch.
//  - Output channel (out_valid/out_ready) carries results: byte writes, fill
//    run commands and one finish status per patch. A byte gives at most two
//    results; end_of_run marks the last of them.
//  - Configuration: cfg_wr_en writes cfg_data to register cfg_index
//    (0 measure_mode, 1 target_size) at once; write only while idle.
//  - Results: a byte's results are registered into the result queue as the byte is taken.
//  - Throughput: one byte per cycle while the receiver keeps up; the parser
//    is a single registered step per byte and the four-entry result queue
//    decouples the two sides.
//  - Receiver stall: the queue fills and in_ready drops once fewer than two
//    free entries remain; nothing is lost or repeated.
//  - Reset: parser returns to the header phase, queue empties, registers clear.
`include "ips_patch_stream_applier_core_defines.svh"
module ips_patch_stream_applier_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [ipsa_pkg::ADDR_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   patch_byte,
  input  logic                         final_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   kind,
  output logic [ipsa_pkg::ADDR_W-1:0]  target_address,
  output logic [15:0]                  run_length,
  output logic [7:0]                   byte_value,
  output logic [1:0]                   status,
  output logic [ipsa_pkg::ADDR_W-1:0]  needed_size,
  output logic                         end_of_run
);
  import ipsa_pkg::*;

  localparam logic CFG_MEASURE = 1'b0;
  localparam logic CFG_TARGET  = 1'b1;

  logic              measure_mode;
  logic [ADDR_W-1:0] target_size;
  logic              step;
  result_t [1:0]     res;
  logic [1:0]        res_cnt;
  logic [1:0]        push_cnt;
  result_t           head;

  always_ff @(posedge clk) begin
    if (rst) begin
      measure_mode <= 1'b0;
      target_size  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MEASURE: measure_mode <= cfg_data[0];
        CFG_TARGET:  target_size  <= cfg_data;
        default:     measure_mode <= measure_mode;
      endcase
    end
  end

  assign step     = in_valid && in_ready;
  assign push_cnt = step ? res_cnt : 2'd0;

  ipsa_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .patch_byte   (patch_byte),
    .final_byte   (final_byte),
    .measure_mode (measure_mode),
    .target_size  (target_size),
    .res          (res),
    .res_cnt      (res_cnt)
  );

  ipsa_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_data (res),
    .push_cnt  (push_cnt),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (head)
  );

  assign kind           = head.kind;
  assign target_address = head.target_address;
  assign run_length     = head.run_length;
  assign byte_value     = head.byte_value;
  assign status         = head.status;
  assign needed_size    = head.needed_size;
  assign end_of_run     = head.end_of_run;

  `IPSA_ASSERT_SAME(a_finish_ends_run, clk, rst, out_valid && kind == KIND_FINISH, end_of_run, "finish result without end_of_run")
  `IPSA_ASSERT_SAME(a_body_no_status, clk, rst, out_valid && kind != KIND_FINISH, status == ST_OK && needed_size == '0, "write or fill carries status")
  `IPSA_ASSERT_SAME(a_stall_has_data, clk, rst, !in_ready, out_valid, "input stalled with empty queue")
  `IPSA_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid && in_ready, "queue not empty after reset")

endmodule

[sim/tb_top.sv]
// Self-checking bench for the IPS patch applier: directed patches, then random patch streams.
// Predicts writes, fill runs and finish statuses from a shadow parser (directed finish rows come
// from the table); needs ipsa_pkg and the ips_patch_stream_applier_core RTL.
module tb_top;
  import ipsa_pkg::*;

  localparam logic REG_MEASURE_MODE = 1'b0;
  localparam logic REG_TARGET_SIZE  = 1'b1;
  localparam logic [ADDR_W-1:0] TARGET_MAX = 25'd16842750;
  localparam logic [39:0] PATCH_TAG = 40'h5041544348;
  localparam int RANDOM_ITEMS  = 1950;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 16;
  localparam int STALL_LIMIT   = 2000;
  localparam int DIR_ROWS      = 32;

  typedef enum logic {ROW_REG, ROW_BYTE} row_op_t;

  typedef struct packed {
    row_op_t           op;
    logic              reg_sel;
    logic [ADDR_W-1:0] value;
    logic              last;
    logic              typed;
    logic [1:0]        exp_status;
    logic [ADDR_W-1:0] exp_need;
  } dir_row_t;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic              cfg_index;
  logic [ADDR_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        patch_byte;
  logic              final_byte;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        kind;
  logic [ADDR_W-1:0] target_address;
  logic [15:0]       run_length;
  logic [7:0]        byte_value;
  logic [1:0]        status;
  logic [ADDR_W-1:0] needed_size;
  logic              end_of_run;

  logic              shadow_measure;
  logic [ADDR_W-1:0] shadow_target;
  logic [2:0]        prs_phase;
  logic [2:0]        prs_index;
  logic [3:0]        prs_count;
  logic [23:0]       prs_address;
  logic [15:0]       prs_length;
  logic [15:0]       prs_remaining;
  logic [ADDR_W-1:0] prs_extent;
  logic [1:0]        prs_error;

  result_t    pending_results[$];
  logic [7:0] patch_bytes[$];
  int         mismatches;
  int         live_bytes;
  int         quiet_cycles;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_REG,  REG_TARGET_SIZE,  TARGET_MAX, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_REG,  REG_MEASURE_MODE, 25'd0,      1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'h50, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'h41, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'h54, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'h43, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'h48, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'hFF, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'hFF, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'hFE, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'h00, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'h01, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'hFF, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'h45, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'h4F, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'h46, 1'b1, 1'b1, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'h50, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'h41, 1'b1, 1'b1, ST_BAD_HDR, 25'd0},
    '{ROW_REG,  REG_MEASURE_MODE, 25'd1,      1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'h50, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'h41, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'h54, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'h43, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'h48, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'hFF, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'hFF, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'hFF, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'h00, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'h00, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'hFF, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'hFF, 1'b0, 1'b0, ST_OK, 25'd0},
    '{ROW_BYTE, 1'b0, 25'h00, 1'b1, 1'b1, ST_TRUNCATED, TARGET_MAX}
  };

  ips_patch_stream_applier_core u_top (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic result_t make_result(input logic [1:0] k, input logic [ADDR_W-1:0] addr,
                                          input logic [15:0] len, input logic [7:0] val,
                                          input logic [1:0] st, input logic [ADDR_W-1:0] need);
    result_t res;
    res = {k, addr, len, val, st, need, 1'b0};
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] record_end();
    return {1'b0, prs_address} + {9'd0, prs_length};
  endfunction

  function automatic void note_extent();
    if (record_end() > prs_extent) prs_extent = record_end();
  endfunction

  function automatic void clear_parser();
    prs_phase     = PH_HEADER;
    prs_index     = '0;
    prs_count     = '0;
    prs_address   = '0;
    prs_length    = '0;
    prs_remaining = '0;
    prs_extent    = '0;
    prs_error     = ST_OK;
  endfunction

  // Advance the shadow parser by one byte and queue the results it implies.
  function automatic void advance_parser(input logic [7:0] b, input logic fin, input bit typed,
                                         input result_t typed_res);
    result_t    step_out[$];
    result_t    last_res;
    logic       eof_hit;
    logic [1:0] fin_status;
    eof_hit = 1'b0;
    live_bytes++;
    if (prs_count < MIN_STREAM) prs_count++;
    if (prs_error == ST_OK) begin
      case (prs_phase)
        PH_HEADER: begin
          if (b != PATCH_TAG[8*(4-prs_index) +: 8]) prs_error = ST_BAD_HDR;
          prs_index++;
          if (prs_index == HDR_LEN) begin
            prs_index = '0;
            prs_phase = PH_ADDR;
          end
        end
        PH_ADDR: begin
          prs_address = {prs_address[15:0], b};
          prs_index++;
          if (prs_index == 3'd3) begin
            prs_index  = '0;
            eof_hit    = (prs_address == EOF_MARK) && fin;
            prs_length = '0;
            prs_phase  = PH_LEN;
          end
        end
        PH_LEN: begin
          prs_length = {prs_length[7:0], b};
          prs_index++;
          if (prs_index == 3'd2) begin
            prs_index = '0;
            if (prs_length == '0) begin
              prs_phase = PH_RLEN;
            end else begin
              prs_remaining = prs_length;
              prs_phase     = PH_DATA;
              if (shadow_measure) note_extent();
              else if (!fin && record_end() > shadow_target) prs_error = ST_BOUNDS;
            end
          end
        end
        PH_DATA: begin
          if (!shadow_measure)
            step_out.push_back(make_result(KIND_WRITE,
                {1'b0, prs_address} + {9'd0, prs_length - prs_remaining}, '0, b, ST_OK, '0));
          prs_remaining--;
          if (prs_remaining == '0) prs_phase = PH_ADDR;
        end
        PH_RLEN: begin
          prs_length = {prs_length[7:0], b};
          prs_index++;
          if (prs_index == 3'd2) begin
            prs_index = '0;
            prs_phase = PH_FILL;
          end
        end
        PH_FILL: begin
          if (shadow_measure) note_extent();
          else if (record_end() > shadow_target) prs_error = ST_BOUNDS;
          else step_out.push_back(make_result(KIND_FILL, {1'b0, prs_address}, prs_length, b,
                                              ST_OK, '0));
          prs_phase = PH_ADDR;
        end
        default: begin
          prs_phase = PH_HEADER;
          prs_index = '0;
        end
      endcase
    end
    if (fin) begin
      if (prs_count < MIN_STREAM) fin_status = ST_BAD_HDR;
      else if (prs_error != ST_OK) fin_status = prs_error;
      else fin_status = eof_hit ? ST_OK : ST_TRUNCATED;
      step_out.push_back(make_result(KIND_FINISH, '0, '0, '0, fin_status, prs_extent));
      clear_parser();
    end
    if (step_out.size() != 0) begin
      last_res = step_out.pop_back();
      last_res.end_of_run = 1'b1;
      step_out.push_back(last_res);
    end
    if (typed) pending_results.push_back(typed_res);
    else foreach (step_out[k]) pending_results.push_back(step_out[k]);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 2);
    else if (r < 97) return $urandom_range(3, 8);
    else return $urandom_range(15, 40);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_target();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return TARGET_MAX;
      2, 3, 4, 5: return ADDR_W'($urandom_range(16, 4096));
      default:    return ADDR_W'($urandom_range(0, TARGET_MAX));
    endcase
  endfunction

  function automatic void add_record();
    logic [23:0] addr;
    logic [23:0] lim;
    logic [15:0] len;
    lim = (shadow_target > 25'hFFFFFF) ? 24'hFFFFFF : shadow_target[23:0];
    case ($urandom_range(0, 15))
      0, 1:    addr = EOF_MARK;
      2:       addr = 24'hFFFFFF;
      3:       addr = '0;
      4, 5:    addr = 24'($urandom());
      default: addr = 24'($urandom_range(0, lim));
    endcase
    patch_bytes.push_back(addr[23:16]);
    patch_bytes.push_back(addr[15:8]);
    patch_bytes.push_back(addr[7:0]);
    if ($urandom_range(0, 1) == 0) begin
      len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 300))
                                         : 16'($urandom_range(1, 6));
      patch_bytes.push_back(len[15:8]);
      patch_bytes.push_back(len[7:0]);
      repeat (len) patch_bytes.push_back(8'($urandom()));
    end else begin
      case ($urandom_range(0, 7))
        0:       len = '0;
        1:       len = 16'hFFFF;
        2:       len = 16'($urandom());
        default: len = 16'($urandom_range(1, 64));
      endcase
      patch_bytes.push_back(8'h00);
      patch_bytes.push_back(8'h00);
      patch_bytes.push_back(len[15:8]);
      patch_bytes.push_back(len[7:0]);
      patch_bytes.push_back(8'($urandom()));
    end
  endfunction

  // Mostly well-formed patches; some with a broken header, cut short, or pure noise.
  function automatic void build_patch();
    int shape;
    int keep;
    int k;
    patch_bytes.delete();
    shape = $urandom_range(0, 19);
    if (shape == 19) begin
      repeat ($urandom_range(1, 24)) patch_bytes.push_back(8'($urandom()));
      return;
    end
    for (k = 0; k < HDR_LEN; k++) patch_bytes.push_back(PATCH_TAG[8*(4-k) +: 8]);
    if (shape == 0) patch_bytes[$urandom_range(0, 4)] ^= 8'($urandom_range(1, 255));
    repeat ($urandom_range(0, 4)) add_record();
    patch_bytes.push_back(EOF_MARK[23:16]);
    patch_bytes.push_back(EOF_MARK[15:8]);
    patch_bytes.push_back(EOF_MARK[7:0]);
    keep = patch_bytes.size();
    if (shape >= 1 && shape <= 4) keep = $urandom_range(1, patch_bytes.size() - 1);
    if (shape == 5) keep = $urandom_range(1, 7);
    while (patch_bytes.size() > keep) void'(patch_bytes.pop_back());
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin, input bit steady,
                           input bit typed, input result_t typed_res);
    int gap;
    gap = steady ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid   = 1'b1;
    patch_byte = b;
    final_byte = fin;
    do @(posedge clk); while (!in_ready);
    advance_parser(b, fin, typed, typed_res);
  endtask

  // Hold the sender until every expected result is out and the parser is quiet.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [ADDR_W-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = sel;
    cfg_data  = val;
    @(posedge clk);
    if (sel == REG_MEASURE_MODE) shadow_measure = val[0];
    else shadow_target = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  initial begin
    int          burst;
    int          stall;
    out_ready = 1'b0;
    forever begin
      burst = $urandom_range(1, 24);
      stall = ($urandom_range(0, 2) == 0) ? 0 : pick_gap();
      repeat (burst) begin
        @(negedge clk);
        out_ready = 1'b1;
      end
      repeat (stall) begin
        @(negedge clk);
        out_ready = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    result_t got_res;
    result_t want_res;
    if (!rst && out_valid && out_ready) begin
      got_res = {kind, target_address, run_length, byte_value, status, needed_size, end_of_run};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d addr %h len %h val %h st %0d need %h eor %b",
                   kind, target_address, run_length, byte_value, status, needed_size,
                   end_of_run);
      end else begin
        want_res = pending_results.pop_front();
        if (got_res !== want_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch (exp/got): kind %0d/%0d addr %h/%h len %h/%h ",
                      "val %h/%h st %0d/%0d need %h/%h eor %b/%b"},
                     want_res.kind, kind, want_res.target_address, target_address,
                     want_res.run_length, run_length, want_res.byte_value, byte_value,
                     want_res.status, status, want_res.needed_size, needed_size,
                     want_res.end_of_run, end_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL ips_patch_stream_applier_core");
      $finish;
    end
  end

  initial begin
    int      r;
    int      i;
    int      flip_at;
    bit      steady;
    bit      first;
    result_t typed_res;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_index      = REG_MEASURE_MODE;
    cfg_data       = '0;
    in_valid       = 1'b0;
    patch_byte     = '0;
    final_byte     = 1'b0;
    shadow_measure = 1'b0;
    shadow_target  = '0;
    mismatches     = 0;
    live_bytes     = 0;
    quiet_cycles   = 0;
    clear_parser();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].op == ROW_REG) begin
        settle();
        write_reg(dir_rows[r].reg_sel, dir_rows[r].value);
      end else begin
        typed_res = make_result(KIND_FINISH, '0, '0, '0, dir_rows[r].exp_status,
                                dir_rows[r].exp_need);
        typed_res.end_of_run = 1'b1;
        send_byte(dir_rows[r].value[7:0], dir_rows[r].last, 1'b0, dir_rows[r].typed,
                  typed_res);
      end
    end

    live_bytes = 0;
    first = 1'b1;
    while (live_bytes < RANDOM_ITEMS) begin
      if (first || $urandom_range(0, 3) == 0) begin
        settle();
        if (first || $urandom_range(0, 1) == 0) write_reg(REG_TARGET_SIZE, pick_target());
        if (first || $urandom_range(0, 1) == 0)
          write_reg(REG_MEASURE_MODE, ADDR_W'($urandom_range(0, 9) < 3));
        first = 1'b0;
      end
      build_patch();
      steady  = ($urandom_range(0, 3) == 0);
      flip_at = ($urandom_range(0, 24) == 0) ? $urandom_range(0, patch_bytes.size() - 1) : -1;
      for (i = 0; i < patch_bytes.size(); i++) begin
        if (i == flip_at) begin
          settle();
          write_reg(REG_MEASURE_MODE, {24'd0, ~shadow_measure});
        end
        send_byte(patch_bytes[i], i == patch_bytes.size() - 1, steady, 1'b0, '0);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("PASS ips_patch_stream_applier_core");
    else
      $display("FAIL ips_patch_stream_applier_core");
    $finish;
  end
endmodule
